// File: rtl/rgb2ycc_pkg.sv
// Shared constants, types and helper functions for the RGB to YCbCr 4:2:0 unit.
// Holds the Q0.16 conversion coefficients and the width clamp rule.
// Depends on nothing; every other file refers to it by scoped names.
package rgb2ycc_pkg;

    // Field widths of the stream and configuration channels.
    localparam int unsigned COMP_W    = 8;
    localparam int unsigned TDATA_W   = 3 * COMP_W;
    localparam int unsigned CFG_W     = 13;
    localparam int unsigned ACC_W     = 25;
    localparam int unsigned FRAC_W    = 16;

    // Line length limit and the width after reset.
    localparam int unsigned MAX_WIDTH_DEF = 4096;
    localparam logic [CFG_W-1:0] WIDTH_RESET = 13'd640;

    // BT.601 full-range coefficients, unsigned Q0.16.
    localparam logic [15:0] KY_R    = 16'd19595;
    localparam logic [15:0] KY_G    = 16'd38470;
    localparam logic [15:0] KY_B    = 16'd7471;
    localparam logic [15:0] KCB_R   = 16'd11058;
    localparam logic [15:0] KCB_G   = 16'd21710;
    localparam logic [15:0] KC_HALF = 16'd32768;
    localparam logic [15:0] KCR_G   = 16'd27439;
    localparam logic [15:0] KCR_B   = 16'd5329;
    localparam logic [ACC_W-1:0] OFFSET_128 = 25'd8388608;

    // Request seen by the position tracker when a pixel is taken.
    typedef struct packed {
        logic accept;
        logic first_of_frame;
    } pos_req_t;

    // Width as the row counter uses it: zero acts as one, large values clamp.
    function automatic logic [31:0] clamp_width(logic [CFG_W-1:0] width,
                                                int unsigned max_width);
        logic [31:0] w;
        begin
            w = 32'(width);
            if (w == 32'd0)
            begin
                w = 32'd1;
            end
            if (w > 32'(max_width))
            begin
                w = 32'(max_width);
            end
            return w;
        end
    endfunction

    // Shift a Q.16 sum down to an integer and saturate it to 0..255.
    function automatic logic [COMP_W-1:0] scale_sat(logic [ACC_W-1:0] acc);
        logic [ACC_W-FRAC_W-1:0] whole;
        begin
            whole = acc[ACC_W-1:FRAC_W];
            if (whole > 9'd255)
            begin
                return 8'd255;
            end
            return whole[COMP_W-1:0];
        end
    endfunction

endpackage

// File: rtl/rgb2ycc_matrix.sv
// Color matrix: 8-bit RGB to full-range BT.601 Y, Cb and Cr in one pass.
// Constant multiplies in Q0.16, truncation, then saturation to 0..255.
// Depends on rgb2ycc_pkg for coefficients and the scale_sat function.
module rgb2ycc_matrix
(
    input  logic [rgb2ycc_pkg::COMP_W-1:0] red,
    input  logic [rgb2ycc_pkg::COMP_W-1:0] green,
    input  logic [rgb2ycc_pkg::COMP_W-1:0] blue,
    output logic [rgb2ycc_pkg::COMP_W-1:0] luma,
    output logic [rgb2ycc_pkg::COMP_W-1:0] chroma_blue,
    output logic [rgb2ycc_pkg::COMP_W-1:0] chroma_red
);

    logic [rgb2ycc_pkg::ACC_W-1:0] r_ext;
    logic [rgb2ycc_pkg::ACC_W-1:0] g_ext;
    logic [rgb2ycc_pkg::ACC_W-1:0] b_ext;
    logic [rgb2ycc_pkg::ACC_W-1:0] y_acc;
    logic [rgb2ycc_pkg::ACC_W-1:0] cb_acc;
    logic [rgb2ycc_pkg::ACC_W-1:0] cr_acc;

    assign r_ext = rgb2ycc_pkg::ACC_W'(red);
    assign g_ext = rgb2ycc_pkg::ACC_W'(green);
    assign b_ext = rgb2ycc_pkg::ACC_W'(blue);

    // Weighted sums; positive terms come first so no sum ever goes negative.
    always_comb
    begin
        y_acc  = rgb2ycc_pkg::ACC_W'(rgb2ycc_pkg::KY_R) * r_ext
               + rgb2ycc_pkg::ACC_W'(rgb2ycc_pkg::KY_G) * g_ext
               + rgb2ycc_pkg::ACC_W'(rgb2ycc_pkg::KY_B) * b_ext;
        cb_acc = rgb2ycc_pkg::OFFSET_128
               + rgb2ycc_pkg::ACC_W'(rgb2ycc_pkg::KC_HALF) * b_ext
               - rgb2ycc_pkg::ACC_W'(rgb2ycc_pkg::KCB_R) * r_ext
               - rgb2ycc_pkg::ACC_W'(rgb2ycc_pkg::KCB_G) * g_ext;
        cr_acc = rgb2ycc_pkg::OFFSET_128
               + rgb2ycc_pkg::ACC_W'(rgb2ycc_pkg::KC_HALF) * r_ext
               - rgb2ycc_pkg::ACC_W'(rgb2ycc_pkg::KCR_G) * g_ext
               - rgb2ycc_pkg::ACC_W'(rgb2ycc_pkg::KCR_B) * b_ext;
    end

    // Drop the fraction and clamp.
    assign luma        = rgb2ycc_pkg::scale_sat(y_acc);
    assign chroma_blue = rgb2ycc_pkg::scale_sat(cb_acc);
    assign chroma_red  = rgb2ycc_pkg::scale_sat(cr_acc);

endmodule

// File: rtl/rgb2ycc_position.sv
// Pixel position tracker: column counter, row parity and the width register.
// Flags the top-left pixel of each 2x2 block as the kept 4:2:0 chroma sample.
// Depends on rgb2ycc_pkg for the width clamp rule and the request struct.
module rgb2ycc_position
#(
    parameter int unsigned MAX_WIDTH = rgb2ycc_pkg::MAX_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [rgb2ycc_pkg::CFG_W-1:0] cfg_width,
    input  rgb2ycc_pkg::pos_req_t         req,
    output logic                          chroma_keep
);

    localparam int unsigned CNT_W = $clog2(MAX_WIDTH);
    localparam logic [31:0] EFF_RESET =
        rgb2ycc_pkg::clamp_width(rgb2ycc_pkg::WIDTH_RESET, MAX_WIDTH);

    logic [CNT_W-1:0] column_reg;
    logic [CNT_W-1:0] column_next;
    logic             row_odd_reg;
    logic             row_odd_next;
    logic [CNT_W:0]   eff_width_reg;
    logic [CNT_W:0]   eff_width_next;
    logic [31:0]      eff_full;
    logic [CNT_W-1:0] column_cur;
    logic             row_odd_cur;
    logic [CNT_W:0]   column_inc;

    // Width register keeps the already clamped line length.
    assign eff_full       = rgb2ycc_pkg::clamp_width(cfg_width, MAX_WIDTH);
    assign eff_width_next = cfg_write ? eff_full[CNT_W:0] : eff_width_reg;

    // Start of frame restarts the position before this pixel is used.
    always_comb
    begin
        column_cur  = req.first_of_frame ? '0 : column_reg;
        row_odd_cur = req.first_of_frame ? 1'b0 : row_odd_reg;
        column_inc  = {1'b0, column_cur} + {{CNT_W{1'b0}}, 1'b1};
    end

    assign chroma_keep = !row_odd_cur && !column_cur[0];

    // Advance one column per accepted pixel, wrapping at the line end.
    always_comb
    begin
        column_next  = column_reg;
        row_odd_next = row_odd_reg;
        if (req.accept)
        begin
            if (column_inc >= eff_width_reg)
            begin
                column_next  = '0;
                row_odd_next = !row_odd_cur;
            end
            else
            begin
                column_next  = column_inc[CNT_W-1:0];
                row_odd_next = row_odd_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg    <= '0;
            row_odd_reg   <= 1'b0;
            eff_width_reg <= EFF_RESET[CNT_W:0];
        end
        else
        begin
            column_reg    <= column_next;
            row_odd_reg   <= row_odd_next;
            eff_width_reg <= eff_width_next;
        end
    end

endmodule

// File: rtl/rgb_to_ycbcr_420_unit.sv
// Top level of the RGB to YCbCr 4:2:0 unit: stream ports, two-stage pipeline.
// Depends on rgb2ycc_pkg, rgb2ycc_position and rgb2ycc_matrix.
//
// Usage:
//   Pixels enter on the s_axis channel in raster order, one per request:
//   red, green and blue in s_axis_tdata, the start-of-frame flag in
//   s_axis_tuser. Each pixel gives exactly one result on m_axis: luma, Cb
//   and Cr in m_axis_tdata, and in m_axis_tuser a flag that marks the pixel
//   whose chroma is kept for 4:2:0 (even column of an even row).
//   The line length is written on the cfg channel (cfg_valid, cfg_ready,
//   cfg_data) while no pixel is in flight; cfg_ready is always high.
//   Each pixel passes the input register, then the color matrix into the
//   output register. Throughput is one pixel per clock while m_axis_tready
//   stays high; both pipeline stages advance together and the input is
//   taken while a finished result still waits downstream.
//   When the receiver holds m_axis_tready low, the output register holds,
//   the input register fills, and s_axis_tready then drops until a result
//   leaves. Reset clears the pipeline, the column counter and row parity,
//   and sets the line length to 640 pixels.
module rgb_to_ycbcr_420_unit
#(
    parameter int unsigned MAX_WIDTH = rgb2ycc_pkg::MAX_WIDTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration: line length in pixels.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rgb2ycc_pkg::CFG_W-1:0]   cfg_data,
    // Input pixels.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [rgb2ycc_pkg::TDATA_W-1:0] s_axis_tdata,  // red, green, blue
    input  logic                            s_axis_tuser,  // first_of_frame
    // Converted pixels.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [rgb2ycc_pkg::TDATA_W-1:0] m_axis_tdata,  // luma, chroma_blue, chroma_red
    output logic                            m_axis_tuser   // chroma_valid
);

    localparam int unsigned CW = rgb2ycc_pkg::COMP_W;

    logic                   s_fire;
    logic                   out_free;
    logic                   s1_advance;
    rgb2ycc_pkg::pos_req_t  pos_req;
    logic                   chroma_keep;

    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic [CW-1:0]          s1_red_reg;
    logic [CW-1:0]          s1_green_reg;
    logic [CW-1:0]          s1_blue_reg;
    logic                   s1_chroma_reg;

    logic [CW-1:0]          luma;
    logic [CW-1:0]          chroma_blue;
    logic [CW-1:0]          chroma_red;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [rgb2ycc_pkg::TDATA_W-1:0] out_data_reg;
    logic                   out_flag_reg;

    // Handshake: the output register frees when empty or being taken.
    assign cfg_ready     = 1'b1;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s1_advance    = s1_valid_reg && out_free;
    assign s_axis_tready = !s1_valid_reg || out_free;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign pos_req.accept         = s_fire;
    assign pos_req.first_of_frame = s_axis_tuser;

    rgb2ycc_position
    #(
        .MAX_WIDTH (MAX_WIDTH)
    )
    u_position
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_width   (cfg_data),
        .req         (pos_req),
        .chroma_keep (chroma_keep)
    );

    // Input stage occupancy.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // Input register: pixel and its chroma flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_chroma_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (s_fire)
            begin
                s1_chroma_reg <= chroma_keep;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            s1_red_reg   <= s_axis_tdata[CW-1:0];
            s1_green_reg <= s_axis_tdata[2*CW-1:CW];
            s1_blue_reg  <= s_axis_tdata[3*CW-1:2*CW];
        end
    end

    rgb2ycc_matrix u_matrix
    (
        .red         (s1_red_reg),
        .green       (s1_green_reg),
        .blue        (s1_blue_reg),
        .luma        (luma),
        .chroma_blue (chroma_blue),
        .chroma_red  (chroma_red)
    );

    // Output stage occupancy.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_data_reg <= {chroma_red, chroma_blue, luma};
            out_flag_reg <= s1_chroma_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_flag_reg;

    // A frame start always lands on a kept chroma sample.
    a_sof_keeps_chroma : assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && s_axis_tuser |=> s1_chroma_reg)
        else $error("start-of-frame pixel not marked as chroma sample");

    // Two pixels in a row within one frame are never both kept samples.
    a_no_adjacent_keep : assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && !s_axis_tuser |-> !(chroma_keep && s1_chroma_reg))
        else $error("adjacent pixels both marked as chroma samples");

    // An emptied pipeline shows no result on the next cycle.
    a_drain_empty : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !s1_valid_reg |=> !m_axis_tvalid)
        else $error("result appeared with no pixel in the input stage");

endmodule
